// ----- hw/rtl/shrc_pkg.sv -----
// Shared widths, register indexes and defaults for the sample-and-hold rate converter.
package shrc_pkg;

    localparam int SAMPLE_W           = 8;
    localparam int SRC_W              = 16;
    localparam int TGT_W              = 20;
    localparam int CFG_INDEX_W        = 2;
    localparam int CFG_DATA_W         = 20;
    localparam int DIV_CNT_W          = $clog2(TGT_W);
    localparam int DEFAULT_MAX_REPEAT = 64;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_RATE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_RATE = 2'd1;

endpackage

// ----- hw/rtl/shrc_div.sv -----
// Bit-serial restoring divider: target rate over source rate, one quotient bit per cycle.
module shrc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [shrc_pkg::TGT_W-1:0] dividend,
    input  logic [shrc_pkg::SRC_W-1:0] divisor,
    output logic                      busy,
    output logic [shrc_pkg::TGT_W-1:0] quotient,
    output logic [shrc_pkg::SRC_W-1:0] remainder
);
    import shrc_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(TGT_W - 1);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TGT_W-1:0]     quot_reg;
    logic [SRC_W-1:0]     rem_reg;
    logic [SRC_W:0]       shifted;
    logic                 fits;
    logic [SRC_W:0]       diff;
    logic [DIV_CNT_W-1:0] bit_sel;

    // One restoring step: shift in the next dividend bit and try the subtraction.
    always_comb
    begin
        bit_sel = LAST_STEP - cnt_reg;
        shifted = {rem_reg, dividend[bit_sel]};
        fits    = shifted >= {1'b0, divisor};
        diff    = shifted - {1'b0, divisor};
    end

    // Iteration control and partial results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[TGT_W-2:0], fits};
            rem_reg  <= fits ? diff[SRC_W-1:0] : shifted[SRC_W-1:0];
            cnt_reg  <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

    // Once the divider settles, the remainder is below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> rem_reg < divisor)
        else $error("divider remainder not below divisor");

endmodule

// ----- hw/rtl/shrc_front.sv -----
// Front end: configuration registers, division setup and per-sample copy count.
module shrc_front #(
    parameter int MAX_REPEAT = shrc_pkg::DEFAULT_MAX_REPEAT,
    parameter int CW         = $clog2(MAX_REPEAT + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [shrc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [shrc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [shrc_pkg::SAMPLE_W-1:0]    sample_in,
    input  logic                            stream_start,
    input  logic                            queue_full,
    output logic                            push,
    output logic [shrc_pkg::SAMPLE_W-1:0]    push_sample,
    output logic [CW-1:0]                   push_count
);
    import shrc_pkg::*;

    localparam int RW = $clog2(MAX_REPEAT);
    localparam logic [TGT_W-1:0] QUOT_MAX = TGT_W'(MAX_REPEAT - 1);

    logic [SRC_W-1:0] source_reg;
    logic [TGT_W-1:0] target_reg;
    logic             running_reg;
    logic [SRC_W-1:0] acc_reg;
    logic [SRC_W-1:0] acc_next;

    logic             cfg_we;
    logic             rate_we;
    logic             accept;
    logic [SRC_W-1:0] divisor;
    logic             div_busy;
    logic [TGT_W-1:0] quot_full;
    logic [SRC_W-1:0] frac_step;
    logic [RW-1:0]    whole_repeat;
    logic [SRC_W-1:0] acc_base;
    logic [SRC_W:0]   acc_sum;
    logic             carry;
    logic             pass_through;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;
    assign in_stall  = div_busy | queue_full;
    assign accept    = in_valid & ~in_stall;

    // Only a write to one of the two rate registers ends the running stream.
    assign rate_we = cfg_we & ((cfg_index == REG_SOURCE_RATE) |
                               (cfg_index == REG_TARGET_RATE));

    // A source rate of zero divides as one.
    assign divisor = (source_reg == '0) ? SRC_W'(1) : source_reg;

    shrc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cfg_we),
        .dividend  (target_reg),
        .divisor   (divisor),
        .busy      (div_busy),
        .quotient  (quot_full),
        .remainder (frac_step)
    );

    // Saturate the whole repeat count and step the phase accumulator.
    always_comb
    begin
        whole_repeat = (quot_full > QUOT_MAX) ? QUOT_MAX[RW-1:0] : quot_full[RW-1:0];
        pass_through = (target_reg == '0);
        acc_base     = (stream_start || !running_reg)
                     ? ((divisor >> 1) + {{(SRC_W-1){1'b0}}, divisor[0]}) : acc_reg;
        acc_sum      = {1'b0, acc_base} + {1'b0, frac_step};
        carry        = acc_sum >= {1'b0, divisor};
        acc_next     = carry ? SRC_W'(acc_sum - {1'b0, divisor}) : acc_sum[SRC_W-1:0];
        if (pass_through)
        begin
            push_count = CW'(1);
        end
        else
        begin
            push_count = CW'(whole_repeat) + CW'(carry);
        end
    end

    assign push        = accept & (push_count != '0);
    assign push_sample = sample_in;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_reg <= SRC_W'(1);
            target_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_RATE: source_reg <= cfg_data[SRC_W-1:0];
                REG_TARGET_RATE: target_reg <= cfg_data[TGT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Stream state: running flag and phase accumulator.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            acc_reg     <= SRC_W'(1);
        end
        else if (rate_we)
        begin
            running_reg <= 1'b0;
        end
        else if (accept)
        begin
            running_reg <= 1'b1;
            if (!pass_through)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    // Running, nonzero target and idle divider: the accumulator stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (running_reg && !pass_through && !div_busy) |-> acc_reg < divisor)
        else $error("phase accumulator out of range");

endmodule

// ----- hw/rtl/shrc_queue.sv -----
// Two-entry queue that holds sample and copy count between the front and back ends.
module shrc_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output logic [DATA_W-1:0] head
);
    logic [DATA_W-1:0] mem [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign full      = count_reg[1];
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    // No pop from an empty queue and no push into a full one.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && count_reg == '0) && !(push && count_reg[1]))
        else $error("queue overflow or underflow");

endmodule

// ----- hw/rtl/shrc_back.sv -----
// Back end: emits the queued sample the requested number of times through an output register.
module shrc_back #(
    parameter int MAX_REPEAT = shrc_pkg::DEFAULT_MAX_REPEAT,
    parameter int CW         = $clog2(MAX_REPEAT + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_not_empty,
    input  logic [shrc_pkg::SAMPLE_W-1:0] q_sample,
    input  logic [CW-1:0]                q_count,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [shrc_pkg::SAMPLE_W-1:0] sample_out,
    output logic                         last_copy
);
    import shrc_pkg::*;

    logic [SAMPLE_W-1:0] cur_sample_reg;
    logic [CW-1:0]       rem_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] sample_out_reg;
    logic                last_copy_reg;
    logic                active;
    logic                emit;
    logic                final_copy;

    // Emit while the output register is free; pop an entry when idle or on the last copy.
    assign active     = (rem_reg != '0);
    assign emit       = active & (~out_valid_reg | ~out_stall);
    assign final_copy = (rem_reg == CW'(1));
    assign pop        = q_not_empty & (~active | (emit & final_copy));

    // Current entry and remaining copies.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (pop)
        begin
            rem_reg <= q_count;
        end
        else if (emit)
        begin
            rem_reg <= rem_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_sample_reg <= q_sample;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            sample_out_reg <= cur_sample_reg;
            last_copy_reg  <= final_copy;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign last_copy  = last_copy_reg;

    // After a copy that is not the last is taken, the next copy follows at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !last_copy_reg) |=> out_valid_reg)
        else $error("gap inside a run of copies");

endmodule

// ----- hw/rtl/sample_hold_rate_converter.sv -----
// Top level of the sample-and-hold rate converter.
//
// Usage: program source_rate (index 0) and target_rate (index 1) on the cfg
// channel, which is always ready. Each write starts a bit-serial division
// of target by source; the input stalls until it finishes. After reset the
// quotient is already valid for the reset register values.
// Input beats carry one sample byte and a stream_start flag; stream_start
// reloads the phase accumulator with half the source rate, rounded up, as
// does the first sample after reset or after any register write.
// Each input beat produces between zero and MAX_REPEAT output beats, the
// final one flagged by last_copy; a target rate of zero passes samples
// through one for one. An accepted beat reaches the output through the queue,
// the back end's entry registers and the output register. The output side
// sustains one beat per cycle while out_stall is low and copies are pending;
// a two-entry queue lets the front end take samples while copies drain.
// When out_stall is high the output register holds its beat; once the queue
// fills, in_stall rises. Reset clears all control state and empties the queue.
module sample_hold_rate_converter #(
    parameter int MAX_REPEAT = shrc_pkg::DEFAULT_MAX_REPEAT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [shrc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [shrc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [shrc_pkg::SAMPLE_W-1:0]    sample_in,
    input  logic                            stream_start,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [shrc_pkg::SAMPLE_W-1:0]    sample_out,
    output logic                            last_copy
);
    import shrc_pkg::*;

    localparam int CW = $clog2(MAX_REPEAT + 1);

    logic                queue_full;
    logic                push;
    logic [SAMPLE_W-1:0] push_sample;
    logic [CW-1:0]       push_count;
    logic                pop;
    logic                q_not_empty;
    logic [SAMPLE_W-1:0] q_sample;
    logic [CW-1:0]       q_count;

    shrc_front #(
        .MAX_REPEAT (MAX_REPEAT),
        .CW         (CW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_in    (sample_in),
        .stream_start (stream_start),
        .queue_full   (queue_full),
        .push         (push),
        .push_sample  (push_sample),
        .push_count   (push_count)
    );

    shrc_queue #(
        .DATA_W (SAMPLE_W + CW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_sample, push_count}),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (q_not_empty),
        .head      ({q_sample, q_count})
    );

    shrc_back #(
        .MAX_REPEAT (MAX_REPEAT),
        .CW         (CW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_sample    (q_sample),
        .q_count     (q_count),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .last_copy   (last_copy)
    );

endmodule
